// ===== rtl/core/cde_pkg.sv =====
package cde_pkg;

	localparam int MAX_TERMS_DEF = 16;
	localparam int ID_BITS_DEF   = 32;
	localparam int DW            = 64;

	typedef enum logic [1:0] {
		FN_HEADER = 2'd0,
		FN_LEFT   = 2'd1,
		FN_RIGHT  = 2'd2,
		FN_EVAL   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		OC_RESIDUE   = 3'd0,
		OC_RANGE     = 3'd1,
		OC_NONLINEAR = 3'd2,
		OC_OVERFLOW  = 3'd3,
		OC_CAPACITY  = 3'd4
	} outcome_t;

	typedef struct packed {
		logic          start;
		logic [DW-1:0] a;
		logic [DW-1:0] b;
	} gcd_req_t;

	typedef struct packed {
		logic          done;
		logic [DW-1:0] g;
	} gcd_rsp_t;

	typedef struct packed {
		logic          start;
		logic [DW-1:0] n;
		logic [DW-1:0] d;
	} mod_req_t;

	typedef struct packed {
		logic          done;
		logic [DW-1:0] r;
	} mod_rsp_t;

endpackage

// ===== rtl/core/cde_if.sv =====
interface cde_in_if;
	import cde_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] term_id;
	logic signed [63:0] coefficient;
	logic signed [63:0] left_constant;
	logic signed [63:0] right_constant;
	logic signed [63:0] lower_bound;
	logic signed [63:0] upper_bound;
	logic [63:0] left_modulus;
	logic [63:0] right_modulus;
	logic        left_linear;
	logic        right_linear;
	modport source (output valid, func, term_id, coefficient, left_constant, right_constant,
		lower_bound, upper_bound, left_modulus, right_modulus, left_linear, right_linear,
		input ready);
	modport sink (input valid, func, term_id, coefficient, left_constant, right_constant,
		lower_bound, upper_bound, left_modulus, right_modulus, left_linear, right_linear,
		output ready);
endinterface

interface cde_out_if;
	logic        valid;
	logic        ready;
	logic        excluded;
	logic [2:0]  outcome;
	logic [63:0] final_modulus;
	modport source (output valid, excluded, outcome, final_modulus, input ready);
	modport sink (input valid, excluded, outcome, final_modulus, output ready);
endinterface

// ===== rtl/core/cde_mod.sv =====
module cde_mod (
	input  logic              clk,
	input  logic              arst_n,
	input  cde_pkg::mod_req_t req,
	output cde_pkg::mod_rsp_t rsp
);
	import cde_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] rem_q, quo_q, d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW-1:0] shifted;

	assign shifted = {rem_q[DW-2:0], quo_q[DW-1]};
	assign trial   = {rem_q, quo_q[DW-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.n;
			d_q   <= req.d;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], 1'b0};
			if (!trial[DW]) rem_q <= trial[DW-1:0];
			else rem_q <= shifted;
		end
	end

	assign rsp.done = done_q;
	assign rsp.r    = rem_q;
endmodule

// ===== rtl/core/congruence_difference_exclusion.sv =====
// Channel | Dir | Payload
// in      | in  | func, term_id, coefficient, constants, window, moduli, linear flags
// out     | out | excluded, outcome, final_modulus
// Term items are stored without leaving ST_IDLE. A header takes a gcd of the two
// moduli by Euclid steps. Evaluate walks the merged terms, one gcd each through
// the shared restoring remainder unit, then two residues.
// Reset clears counts, flags and saved header values; term stores are not cleared.
// in.ready is low while an item is at work; a finished result holds in ST_OUT
// while out still holds the previous one.
module congruence_difference_exclusion #(
	parameter int MAX_TERMS = cde_pkg::MAX_TERMS_DEF,
	parameter int ID_BITS   = cde_pkg::ID_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	cde_in_if.sink    in,
	cde_out_if.source out
);
	import cde_pkg::*;

	localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW = $clog2(MAX_TERMS + 1);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_HGCD   = 11'b00000000010,
		ST_FETCH  = 11'b00000000100,
		ST_PICK   = 11'b00000001000,
		ST_GCD    = 11'b00000010000,
		ST_GWAIT  = 11'b00000100000,
		ST_RES1   = 11'b00001000000,
		ST_RWAIT1 = 11'b00010000000,
		ST_RES2   = 11'b00100000000,
		ST_RWAIT2 = 11'b01000000000,
		ST_OUT    = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [ID_BITS-1:0] lid_mem [MAX_TERMS];
	logic [DW-1:0]      lco_mem [MAX_TERMS];
	logic [ID_BITS-1:0] rid_mem [MAX_TERMS];
	logic [DW-1:0]      rco_mem [MAX_TERMS];
	logic [ID_BITS-1:0] lid_q, rid_q;
	logic [DW-1:0]      lco_q, rco_q;

	logic [CW-1:0] lcnt_q, rcnt_q, li_q, ri_q;
	logic          over_q;
	logic [1:0]    lin_q;
	logic [DW-1:0] lc_q, rc_q, lo_q, up_q, smod_q;
	logic [DW-1:0] ga_q, gb_q, k_q, r_q;
	logic          hdr_q;
	logic          excl_q;
	logic [2:0]    oc_q;
	logic [DW-1:0] fm_q;
	logic          oexcl_q;
	logic [2:0]    ooc_q;
	logic [DW-1:0] ofm_q;

	mod_req_t mreq;
	mod_rsp_t mrsp;

	cde_mod u_mod (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	logic          acc;
	logic [DW-1:0] kdiff, cdiff, pick_c, mag_c, mag_k, mag_lo, res;
	logic          kov, cov;
	logic          lend, rend, take_l, take_r;
	logic [DW-1:0] neg_src;
	logic [DW-1:0] gap;

	assign acc = in.valid && in.ready;
	assign in.ready = (state_q == ST_IDLE);

	assign kdiff = lc_q - rc_q;
	assign kov   = (lc_q[DW-1] ^ rc_q[DW-1]) & (lc_q[DW-1] ^ kdiff[DW-1]);
	assign cdiff = lco_q - rco_q;
	assign cov   = (lco_q[DW-1] ^ rco_q[DW-1]) & (lco_q[DW-1] ^ cdiff[DW-1]);

	assign lend   = (li_q == lcnt_q);
	assign rend   = (ri_q == rcnt_q);
	assign take_l = rend || (!lend && lid_q < rid_q);
	assign take_r = !take_l && (lend || rid_q < lid_q);
	assign pick_c = take_l ? lco_q : (take_r ? rco_q : cdiff);
	assign mag_c  = pick_c[DW-1] ? '0 - pick_c : pick_c;
	assign mag_k  = k_q[DW-1] ? '0 - k_q : k_q;
	assign mag_lo = lo_q[DW-1] ? '0 - lo_q : lo_q;

	assign neg_src = (state_q == ST_RWAIT1) ? k_q : lo_q;
	assign res = (neg_src[DW-1] && mrsp.r != '0) ? ga_q - mrsp.r : mrsp.r;
	assign gap = (r_q >= res) ? r_q - res : ga_q - (res - r_q);

	always_comb begin
		mreq.start = 1'b0;
		mreq.n     = ga_q;
		mreq.d     = gb_q;
		case (state_q)
			ST_HGCD, ST_GCD: mreq.start = (gb_q != '0);
			ST_RES1: begin
				mreq.start = 1'b1;
				mreq.n     = mag_k;
				mreq.d     = ga_q;
			end
			ST_RES2: begin
				mreq.start = 1'b1;
				mreq.n     = mag_lo;
				mreq.d     = ga_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc && in.func == FN_LEFT && lcnt_q < CW'(MAX_TERMS)) begin
			lid_mem[lcnt_q[IW-1:0]] <= ID_BITS'(in.term_id);
			lco_mem[lcnt_q[IW-1:0]] <= in.coefficient;
		end
		if (acc && in.func == FN_RIGHT && rcnt_q < CW'(MAX_TERMS)) begin
			rid_mem[rcnt_q[IW-1:0]] <= ID_BITS'(in.term_id);
			rco_mem[rcnt_q[IW-1:0]] <= in.coefficient;
		end
		lid_q <= lid_mem[li_q[IW-1:0]];
		lco_q <= lco_mem[li_q[IW-1:0]];
		rid_q <= rid_mem[ri_q[IW-1:0]];
		rco_q <= rco_mem[ri_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			lcnt_q    <= '0;
			rcnt_q    <= '0;
			li_q      <= '0;
			ri_q      <= '0;
			over_q    <= 1'b0;
			lin_q     <= 2'b11;
			lc_q      <= '0;
			rc_q      <= '0;
			lo_q      <= '0;
			up_q      <= '0;
			smod_q    <= '0;
			ga_q      <= '0;
			gb_q      <= '0;
			k_q       <= '0;
			r_q       <= '0;
			hdr_q     <= 1'b0;
			out.valid <= 1'b0;
			excl_q    <= 1'b0;
			oc_q      <= OC_RESIDUE;
			fm_q      <= '0;
			oexcl_q   <= 1'b0;
			ooc_q     <= OC_RESIDUE;
			ofm_q     <= '0;
		end else begin
			if (state_q == ST_OUT && (!out.valid || out.ready)) out.valid <= 1'b1;
			else if (out.ready) out.valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (func_t'(in.func))
							FN_HEADER: begin
								lc_q   <= in.left_constant;
								rc_q   <= in.right_constant;
								lo_q   <= in.lower_bound;
								up_q   <= in.upper_bound;
								lin_q  <= {in.right_linear, in.left_linear};
								lcnt_q <= '0;
								rcnt_q <= '0;
								over_q <= 1'b0;
								ga_q   <= in.left_modulus;
								gb_q   <= in.right_modulus;
								hdr_q  <= 1'b1;
								state_q <= ST_HGCD;
							end
							FN_LEFT: begin
								if (lcnt_q < CW'(MAX_TERMS)) lcnt_q <= lcnt_q + 1'b1;
								else over_q <= 1'b1;
							end
							FN_RIGHT: begin
								if (rcnt_q < CW'(MAX_TERMS)) rcnt_q <= rcnt_q + 1'b1;
								else over_q <= 1'b1;
							end
							default: begin
								excl_q <= 1'b0;
								fm_q   <= '0;
								if (lin_q != 2'b11) begin
									oc_q <= OC_NONLINEAR;
									state_q <= ST_OUT;
								end else if (over_q) begin
									oc_q <= OC_CAPACITY;
									state_q <= ST_OUT;
								end else if (kov) begin
									oc_q <= OC_OVERFLOW;
									state_q <= ST_OUT;
								end else begin
									k_q   <= kdiff;
									ga_q  <= smod_q;
									li_q  <= '0;
									ri_q  <= '0;
									hdr_q <= 1'b0;
									state_q <= ST_FETCH;
								end
							end
						endcase
					end
				end
				ST_HGCD, ST_GCD: begin
					if (gb_q == '0) begin
						if (hdr_q) begin
							smod_q  <= ga_q;
							state_q <= ST_IDLE;
						end else state_q <= ST_FETCH;
					end else state_q <= ST_GWAIT;
				end
				ST_GWAIT: begin
					if (mrsp.done) begin
						ga_q <= gb_q;
						gb_q <= mrsp.r;
						state_q <= hdr_q ? ST_HGCD : ST_GCD;
					end
				end
				ST_FETCH: begin
					if (lend && rend) begin
						if (ga_q == '0) begin
							excl_q <= ($signed(k_q) < $signed(lo_q)) ||
								($signed(k_q) > $signed(up_q));
							oc_q <= OC_RANGE;
							state_q <= ST_OUT;
						end else state_q <= ST_RES1;
					end else state_q <= ST_PICK;
				end
				ST_PICK: begin
					if (!take_l && !take_r && cov) begin
						oc_q <= OC_OVERFLOW;
						state_q <= ST_OUT;
					end else begin
						if (!take_r) li_q <= li_q + 1'b1;
						if (!take_l) ri_q <= ri_q + 1'b1;
						gb_q <= mag_c;
						state_q <= ST_GCD;
					end
				end
				ST_RES1: state_q <= ST_RWAIT1;
				ST_RWAIT1: begin
					if (mrsp.done) begin
						r_q <= res;
						state_q <= ST_RES2;
					end
				end
				ST_RES2: state_q <= ST_RWAIT2;
				ST_RWAIT2: begin
					if (mrsp.done) begin
						excl_q <= gap > (up_q - lo_q);
						oc_q   <= OC_RESIDUE;
						fm_q   <= ga_q;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out.valid || out.ready) begin
						oexcl_q <= excl_q;
						ooc_q   <= oc_q;
						ofm_q   <= fm_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out.excluded      = oexcl_q;
	assign out.outcome       = ooc_q;
	assign out.final_modulus = ofm_q;
endmodule

// ===== bench/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cde_pkg::*;

	localparam int MAXT = MAX_TERMS_DEF;
	localparam int N_ITEMS = 1450;

	typedef struct {
		func_t       func;
		logic [31:0] id;
		logic [63:0] coef, lc, rc, lo, hi, lm, rm;
		logic        ll, rl;
	} item_t;

	typedef struct {
		logic        excluded;
		outcome_t    outcome;
		logic [63:0] modulus;
	} verdict_t;

	typedef struct {
		item_t    it;
		bit       typed;
		verdict_t want;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	cde_in_if in_ch();
	cde_out_if out_ch();

	congruence_difference_exclusion uut (.clk(clk), .arst_n(arst_n), .in(in_ch), .out(out_ch));

	always #5 clk = ~clk;

	// predictor state
	logic [31:0] l_ids [MAXT];
	logic [63:0] l_coefs [MAXT];
	logic [31:0] r_ids [MAXT];
	logic [63:0] r_coefs [MAXT];
	int          l_cnt = 0, r_cnt = 0;
	bit          overfill = 0;
	logic [63:0] s_lc = 0, s_rc = 0, s_lo = 0, s_hi = 0, s_mod = 0;
	logic [1:0]  lin = 2'b11;

	verdict_t    pending_verdicts[$];
	row_t        dir_rows[$];
	int          errors = 0;
	int          sent = 0;
	bit          quiet = 0;
	bit          hold_req = 0;

	function automatic logic [63:0] gcd_u(logic [63:0] a, logic [63:0] b);
		logic [63:0] t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic logic [63:0] mag(logic [63:0] v);
		return v[63] ? 64'd0 - v : v;
	endfunction

	function automatic bit sub_ok(logic [63:0] a, logic [63:0] b, output logic [63:0] d);
		d = a - b;
		return !(((a ^ b) & (a ^ d)) >> 63);
	endfunction

	function automatic logic [63:0] residue(logic [63:0] v, logic [63:0] m);
		logic [63:0] r;
		r = mag(v) % m;
		return (v[63] && r != 0) ? m - r : r;
	endfunction

	function automatic verdict_t judge();
		verdict_t    v;
		logic [63:0] k, g, c, r, lr, gap;
		int          li, ri;
		v = '{1'b0, OC_RESIDUE, 64'd0};
		li = 0;
		ri = 0;
		if (lin != 2'b11) begin
			v.outcome = OC_NONLINEAR;
			return v;
		end
		if (overfill) begin
			v.outcome = OC_CAPACITY;
			return v;
		end
		if (!sub_ok(s_lc, s_rc, k)) begin
			v.outcome = OC_OVERFLOW;
			return v;
		end
		g = s_mod;
		while (li < l_cnt || ri < r_cnt) begin
			if (ri == r_cnt || (li < l_cnt && l_ids[li] < r_ids[ri])) begin
				c = l_coefs[li];
				li++;
			end else if (li == l_cnt || r_ids[ri] < l_ids[li]) begin
				c = r_coefs[ri];
				ri++;
			end else begin
				if (!sub_ok(l_coefs[li], r_coefs[ri], c)) begin
					v.outcome = OC_OVERFLOW;
					return v;
				end
				li++;
				ri++;
			end
			g = gcd_u(g, mag(c));
		end
		if (g == 0) begin
			v.outcome = OC_RANGE;
			v.excluded = ($signed(k) < $signed(s_lo)) || ($signed(k) > $signed(s_hi));
			return v;
		end
		r = residue(k, g);
		lr = residue(s_lo, g);
		gap = (r >= lr) ? r - lr : g - (lr - r);
		v.excluded = gap > (s_hi - s_lo);
		v.modulus = g;
		return v;
	endfunction

	function automatic bit absorb(item_t it, output verdict_t v);
		v = '{1'b0, OC_RESIDUE, 64'd0};
		case (it.func)
			FN_HEADER: begin
				s_lc = it.lc;
				s_rc = it.rc;
				s_lo = it.lo;
				s_hi = it.hi;
				s_mod = gcd_u(it.lm, it.rm);
				lin = {it.rl, it.ll};
				l_cnt = 0;
				r_cnt = 0;
				overfill = 0;
			end
			FN_LEFT: begin
				if (l_cnt < MAXT) begin
					l_ids[l_cnt] = it.id;
					l_coefs[l_cnt] = it.coef;
					l_cnt++;
				end else overfill = 1;
			end
			FN_RIGHT: begin
				if (r_cnt < MAXT) begin
					r_ids[r_cnt] = it.id;
					r_coefs[r_cnt] = it.coef;
					r_cnt++;
				end else overfill = 1;
			end
			default: begin
				v = judge();
				return 1;
			end
		endcase
		return 0;
	endfunction

	function automatic item_t blank(func_t f);
		item_t it;
		it = '{f, 32'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1, 1'b1};
		return it;
	endfunction

	function automatic item_t hdr(logic [63:0] lc, logic [63:0] rc, logic [63:0] lo,
			logic [63:0] hi, logic [63:0] lm, logic [63:0] rm, logic ll, logic rl);
		item_t it;
		it = blank(FN_HEADER);
		it.lc = lc;
		it.rc = rc;
		it.lo = lo;
		it.hi = hi;
		it.lm = lm;
		it.rm = rm;
		it.ll = ll;
		it.rl = rl;
		return it;
	endfunction

	function automatic item_t term(func_t f, logic [31:0] id, logic [63:0] coef);
		item_t it;
		it = blank(f);
		it.id = id;
		it.coef = coef;
		return it;
	endfunction

	function automatic logic [63:0] wide_or_small(int span);
		logic [63:0] v;
		case ($urandom_range(15))
			0: v = {$urandom, $urandom};
			1: v = 64'h7fff_ffff_ffff_ffff;
			2: v = 64'h8000_0000_0000_0000;
			3: v = '1;
			default: v = 64'($signed($urandom_range(2 * span)) - span);
		endcase
		return v;
	endfunction

	function automatic logic [63:0] rnd_mod();
		case ($urandom_range(7))
			0, 1, 2: return 64'd0;
			3: return (($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'(-1));
			default: return 64'($urandom_range(1, 60));
		endcase
	endfunction

	function automatic item_t rnd_header();
		logic [63:0] lo;
		item_t       it;
		lo = wide_or_small(40);
		it = hdr(wide_or_small(100), wide_or_small(100), lo,
			($urandom_range(7) == 0) ? wide_or_small(40) : lo + $urandom_range(0, 20),
			rnd_mod(), rnd_mod(), $urandom_range(15) != 0, $urandom_range(15) != 0);
		return it;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic send(item_t it, bit typed, verdict_t want);
		verdict_t v;
		if (!quiet && $urandom_range(4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_ch.func <= it.func;
		in_ch.term_id <= it.id;
		in_ch.coefficient <= it.coef;
		in_ch.left_constant <= it.lc;
		in_ch.right_constant <= it.rc;
		in_ch.lower_bound <= it.lo;
		in_ch.upper_bound <= it.hi;
		in_ch.left_modulus <= it.lm;
		in_ch.right_modulus <= it.rm;
		in_ch.left_linear <= it.ll;
		in_ch.right_linear <= it.rl;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		if (absorb(it, v)) pending_verdicts.push_back(typed ? want : v);
		sent++;
	endtask

	task automatic add_row(item_t it, bit typed = 0, logic ex = 0,
			outcome_t oc = OC_RESIDUE, logic [63:0] m = 0);
		row_t r;
		r.it = it;
		r.typed = typed;
		r.want = '{ex, oc, m};
		dir_rows.push_back(r);
	endtask

	always @(posedge clk) begin
		verdict_t w;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				report("unexpected result", 64'd1, 64'd0);
			end else begin
				w = pending_verdicts.pop_front();
				if (out_ch.excluded !== w.excluded) report("excluded", out_ch.excluded, w.excluded);
				if (out_ch.outcome !== w.outcome) report("outcome", out_ch.outcome, w.outcome);
				if (out_ch.final_modulus !== w.modulus)
					report("final_modulus", out_ch.final_modulus, w.modulus);
			end
		end
	end

	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else if (!quiet && $urandom_range(5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9) - 1) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		#2s;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		item_t       it;
		verdict_t    none;
		logic [31:0] id;
		int          nl, nr, reps;
		none = '{1'b0, OC_RESIDUE, 64'd0};
		in_ch.valid <= 1'b0;
		in_ch.func <= FN_HEADER;
		in_ch.term_id <= '0;
		in_ch.coefficient <= '0;
		in_ch.left_constant <= '0;
		in_ch.right_constant <= '0;
		in_ch.lower_bound <= '0;
		in_ch.upper_bound <= '0;
		in_ch.left_modulus <= '0;
		in_ch.right_modulus <= '0;
		in_ch.left_linear <= 1'b1;
		in_ch.right_linear <= 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(blank(FN_EVAL), 1, 1'b0, OC_RANGE, 64'd0);
		add_row(hdr(0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
		add_row(blank(FN_EVAL), 1, 1'b0, OC_NONLINEAR, 64'd0);
		add_row(hdr(64'h7fff_ffff_ffff_ffff, '1, 0, 0, 0, 0, 1'b1, 1'b1));
		add_row(blank(FN_EVAL), 1, 1'b0, OC_OVERFLOW, 64'd0);
		add_row(hdr(5, 0, 1, 10, 0, 0, 1'b1, 1'b1));
		add_row(term(FN_LEFT, 32'd3, 64'd2));
		add_row(term(FN_RIGHT, 32'd3, 64'd2));
		add_row(blank(FN_EVAL));
		add_row(term(FN_LEFT, '1, 64'h8000_0000_0000_0000));
		add_row(blank(FN_EVAL));
		add_row(hdr(7, 2, 10, 3, '1, 64'd6, 1'b1, 1'b1));
		add_row(term(FN_LEFT, 32'd9, 64'd4));
		add_row(term(FN_LEFT, 32'd2, 64'd10));
		add_row(term(FN_RIGHT, 32'd0, 64'h7fff_ffff_ffff_ffff));
		add_row(blank(FN_EVAL));
		add_row(hdr(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
			64'h7fff_ffff_ffff_ffff, 0, 0, 1'b1, 1'b1));
		add_row(term(FN_LEFT, 32'd1, 64'h8000_0000_0000_0000));
		add_row(term(FN_RIGHT, 32'd1, 64'd1));
		add_row(blank(FN_EVAL), 1, 1'b0, OC_OVERFLOW, 64'd0);
		add_row(hdr(0, 0, 0, 0, 64'd12, 64'd18, 1'b1, 1'b1));
		add_row(blank(FN_EVAL), 1, 1'b0, OC_RESIDUE, 64'd6);
		foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

		while (sent < N_ITEMS) begin
			if (sent > 300 && sent < 320) hold_req = 1;
			if (sent > N_ITEMS - 150) quiet = 1;
			if ($urandom_range(9) == 0) begin
				it = blank(func_t'($urandom_range(3)));
				it.id = $urandom;
				it.coef = wide_or_small(30);
				send(it, 0, none);
				continue;
			end
			send(rnd_header(), 0, none);
			nl = ($urandom_range(11) == 0) ? $urandom_range(16, 18) : $urandom_range(0, 5);
			nr = ($urandom_range(11) == 0) ? $urandom_range(16, 18) : $urandom_range(0, 5);
			id = ($urandom_range(7) == 0) ? 32'hffff_fff0 : $urandom_range(0, 3);
			while (nl > 0 || nr > 0) begin
				if ($urandom_range(2) != 0) id = id + $urandom_range(1, 2);
				if ($urandom_range(15) == 0) id = $urandom;
				if (nl > 0 && (nr == 0 || $urandom_range(1))) begin
					send(term(FN_LEFT, id, wide_or_small(30)), 0, none);
					nl--;
				end else begin
					send(term(FN_RIGHT, id, wide_or_small(30)), 0, none);
					nr--;
				end
			end
			reps = ($urandom_range(5) == 0) ? 2 : 1;
			repeat (reps) send(blank(FN_EVAL), 0, none);
		end
		in_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/cde_pkg.sv
rtl/core/cde_if.sv
rtl/core/cde_mod.sv
rtl/core/congruence_difference_exclusion.sv
bench/testbench.sv
